// ===== sv/rcs_pkg.sv =====
// Shared types, codes and constants for the risc16 core step block.
package rcs_pkg;

  localparam int unsigned RegCount = 8;
  localparam int unsigned RegIdxW  = $clog2(RegCount);

  localparam logic [15:0] PcReset   = 16'h8200;
  localparam logic [2:0]  NzpReset  = 3'b010;
  localparam logic [15:0] ClearLast = 16'hFFFF;

  // item opcodes
  localparam logic [1:0] ITEM_WR   = 2'd0;
  localparam logic [1:0] ITEM_EXEC = 2'd1;
  localparam logic [1:0] ITEM_RD   = 2'd2;
  localparam logic [1:0] ITEM_NONE = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_CODE    = 3'd1;
  localparam logic [2:0] ST_DATA    = 3'd2;
  localparam logic [2:0] ST_PRIV    = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;

  // instruction opcodes
  localparam logic [3:0] OP_BR    = 4'h0;
  localparam logic [3:0] OP_ARITH = 4'h1;
  localparam logic [3:0] OP_CMP   = 4'h2;
  localparam logic [3:0] OP_JSR   = 4'h4;
  localparam logic [3:0] OP_LOGIC = 4'h5;
  localparam logic [3:0] OP_LDR   = 4'h6;
  localparam logic [3:0] OP_STR   = 4'h7;
  localparam logic [3:0] OP_RTI   = 4'h8;
  localparam logic [3:0] OP_CONST = 4'h9;
  localparam logic [3:0] OP_SHIFT = 4'hA;
  localparam logic [3:0] OP_JMP   = 4'hC;
  localparam logic [3:0] OP_HICON = 4'hD;
  localparam logic [3:0] OP_TRAP  = 4'hF;

  localparam logic [1:0] ARITH_DIV = 2'd3;
  localparam logic [1:0] SHIFT_MOD = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] address;
    logic [15:0] data;
  } rcs_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [15:0]        next_pc;
    logic [2:0]         nzp;
    logic               privilege;
    logic               reg_write;
    logic [RegIdxW-1:0] reg_index;
    logic [15:0]        reg_value;
    logic               mem_write;
    logic [15:0]        mem_addr;
    logic [15:0]        mem_data;
  } rcs_out_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READBACK, S_DECODE, S_EXEC, S_DIVIDE, S_LOAD
  } rcs_state_e;

  typedef struct packed {
    logic clr;        // write zero at clear counter
    logic accept;     // input beat taken
    logic regrd;      // latch instruction and register operands
    logic div_start;
    logic div_step;
    logic load_issue; // read memory at load address
    logic commit;     // retire instruction into result register
    logic readback;   // load read-back result
  } rcs_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic need_div;
    logic need_load;
    logic div_done;
  } rcs_sts_t;

endpackage

// ===== sv/rcs_ctrl.sv =====
// Sequencer for the risc16 core step: clear pass, item handshake, instruction phases.
module rcs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           in_opcode_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  rcs_pkg::rcs_sts_t    sts_i,
  output rcs_pkg::rcs_cmd_t    cmd_o
);
  import rcs_pkg::*;

  rcs_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          if (in_opcode_i == ITEM_EXEC) begin
            state_d = S_DECODE;
          end else if (in_opcode_i == ITEM_RD) begin
            state_d = S_READBACK;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      S_READBACK: begin
        cmd_o.readback = 1'b1;
        out_valid_d    = 1'b1;
        state_d        = S_IDLE;
      end
      S_DECODE: begin
        cmd_o.regrd = 1'b1;
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIVIDE;
        end else if (sts_i.need_load) begin
          cmd_o.load_issue = 1'b1;
          state_d          = S_LOAD;
        end else begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_DIVIDE: begin
        if (sts_i.div_done) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_LOAD: begin
        cmd_o.commit = 1'b1;
        out_valid_d  = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // a result is only produced into a free or draining output slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.commit || cmd_o.readback) |-> !(out_valid_q && out_stall_i))
    else $error("result overwrites a stalled beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (state_q == S_EXEC || state_q == S_DIVIDE || state_q == S_LOAD))
    else $error("commit outside instruction phases");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !out_valid_q)
    else $error("result during clear pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> (state_q == S_DIVIDE))
    else $error("divider started without divide phase");

endmodule

// ===== sv/rcs_dp.sv =====
// Datapath: memory, register file, PC/PSR, execute logic, divider and result register.
module rcs_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rcs_pkg::rcs_in_t    in_data_i,
  input  rcs_pkg::rcs_cmd_t   cmd_i,
  output rcs_pkg::rcs_sts_t   sts_o,
  output rcs_pkg::rcs_out_t   out_data_o
);
  import rcs_pkg::*;

  logic [15:0] mem [65536];
  logic [15:0] rd_data_q;
  logic [15:0] regs [RegCount];
  logic [RegCount-1:0] vld_q, vld_d;

  logic [15:0] pc_q, pc_d;
  logic [2:0]  nzp_q, nzp_d;
  logic        priv_q, priv_d;
  logic [15:0] clr_cnt_q;
  logic [15:0] addr_q;
  logic [15:0] insn_q, ra_q, rb_q;
  logic [15:0] dq_q, dr_q;
  logic [4:0]  dcnt_q;
  rcs_out_t    out_q;

  // memory port control
  logic        mem_we, mem_re;
  logic [15:0] mem_wa, mem_wd, mem_ra;

  // execute
  logic [3:0]  opc;
  logic [15:0] pc1, val, npc, maddr, ldiv;
  logic [2:0]  nz, rd, st;
  logic        wr, setnzp, ld, sto, priv_clr, priv_set, ok;
  logic [RegIdxW-1:0] ia, ib;
  logic [15:0] dinsn;
  logic [16:0] dt, dsub;

  assign opc = insn_q[15:12];
  assign pc1 = pc_q + 16'd1;

  function automatic logic [2:0] nzp_of(logic [15:0] v);
    if (v == 16'd0) return 3'b010;
    return v[15] ? 3'b100 : 3'b001;
  endfunction

  function automatic logic [2:0] cmp_of(logic [16:0] a, logic [16:0] b);
    if ($signed(a) < $signed(b)) return 3'b100;
    return (a == b) ? 3'b010 : 3'b001;
  endfunction

  always_comb begin
    val = 16'd0; npc = pc1; maddr = ra_q + {{10{insn_q[5]}}, insn_q[5:0]};
    nz = 3'b000; rd = insn_q[11:9]; st = ST_OK;
    wr = 1'b0; setnzp = 1'b0; ld = 1'b0; sto = 1'b0;
    priv_clr = 1'b0; priv_set = 1'b0;
    ldiv = (rb_q == 16'd0) ? 16'd0 : dq_q;
    case (opc)
      OP_BR: begin
        if ((nzp_q & insn_q[11:9]) != 3'b000)
          npc = pc1 + {{7{insn_q[8]}}, insn_q[8:0]};
      end
      OP_ARITH: begin
        wr = 1'b1; setnzp = 1'b1;
        if (insn_q[5]) begin
          val = ra_q + {{11{insn_q[4]}}, insn_q[4:0]};
        end else begin
          case (insn_q[4:3])
            2'd0:    val = ra_q + rb_q;
            2'd1:    val = 16'(ra_q * rb_q);
            2'd2:    val = ra_q - rb_q;
            default: val = ldiv;
          endcase
        end
      end
      OP_CMP: begin
        setnzp = 1'b1;
        case (insn_q[8:7])
          2'd0:    nz = cmp_of({ra_q[15], ra_q}, {rb_q[15], rb_q});
          2'd1:    nz = cmp_of({1'b0, ra_q}, {1'b0, rb_q});
          2'd2:    nz = cmp_of({ra_q[15], ra_q}, {{10{insn_q[6]}}, insn_q[6:0]});
          default: nz = cmp_of({1'b0, ra_q}, {10'd0, insn_q[6:0]});
        endcase
      end
      OP_JSR: begin
        wr = 1'b1; setnzp = 1'b1; rd = 3'd7; val = pc1;
        npc = insn_q[11] ? {pc_q[15], insn_q[10:0], 4'd0} : ra_q;
      end
      OP_LOGIC: begin
        wr = 1'b1; setnzp = 1'b1;
        if (insn_q[5]) begin
          val = ra_q & {{11{insn_q[4]}}, insn_q[4:0]};
        end else begin
          case (insn_q[4:3])
            2'd0:    val = ra_q & rb_q;
            2'd1:    val = ~ra_q;
            2'd2:    val = ra_q | rb_q;
            default: val = ra_q ^ rb_q;
          endcase
        end
      end
      OP_LDR: begin
        wr = 1'b1; setnzp = 1'b1; ld = 1'b1; val = rd_data_q;
      end
      OP_STR:   sto = 1'b1;
      OP_RTI: begin
        npc = rb_q; priv_clr = 1'b1;
      end
      OP_CONST: begin
        wr = 1'b1; setnzp = 1'b1; val = {{7{insn_q[8]}}, insn_q[8:0]};
      end
      OP_SHIFT: begin
        wr = 1'b1; setnzp = 1'b1;
        case (insn_q[5:4])
          2'd0:    val = ra_q << insn_q[3:0];
          2'd1:    val = 16'($signed(ra_q) >>> insn_q[3:0]);
          2'd2:    val = ra_q >> insn_q[3:0];
          default: val = (rb_q == 16'd0) ? 16'd0 : dr_q;
        endcase
      end
      OP_JMP: begin
        npc = insn_q[11] ? pc1 + {{5{insn_q[10]}}, insn_q[10:0]} : ra_q;
      end
      OP_HICON: begin
        wr = 1'b1; setnzp = 1'b1; val = {insn_q[7:0], ra_q[7:0]};
      end
      OP_TRAP: begin
        wr = 1'b1; setnzp = 1'b1; rd = 3'd7; val = pc1;
        npc = {8'h80, insn_q[7:0]}; priv_set = 1'b1;
      end
      default: st = ST_INVALID;
    endcase
    if (setnzp && opc != OP_CMP) nz = nzp_of(val);
    // exception priority: code region, privilege, invalid opcode, data region
    if ((pc_q >= 16'h4000 && pc_q <= 16'h7FFF) || pc_q >= 16'hA000) begin
      st = ST_CODE;
    end else if (!priv_q && pc_q[15]) begin
      st = ST_PRIV;
    end else if (st == ST_OK && (ld || sto) &&
                 !((maddr >= 16'h4000 && maddr <= 16'h7FFF) ||
                   (priv_q && maddr >= 16'hA000))) begin
      st = ST_DATA;
    end
    ok = (st == ST_OK);
  end

  assign sts_o.clear_done = (clr_cnt_q == ClearLast);
  assign sts_o.need_div   = ok && ((opc == OP_ARITH && !insn_q[5] && insn_q[4:3] == ARITH_DIV) ||
                                   (opc == OP_SHIFT && insn_q[5:4] == SHIFT_MOD));
  assign sts_o.need_load  = ok && ld;
  assign sts_o.div_done   = dcnt_q[4];

  // memory port
  always_comb begin
    mem_we = 1'b0; mem_wa = clr_cnt_q; mem_wd = 16'd0;
    mem_re = 1'b0; mem_ra = pc_q;
    if (cmd_i.clr) begin
      mem_we = 1'b1;
    end else if (cmd_i.accept) begin
      mem_we = (in_data_i.opcode == ITEM_WR);
      mem_wa = in_data_i.address;
      mem_wd = in_data_i.data;
      mem_re = 1'b1;
      mem_ra = (in_data_i.opcode == ITEM_EXEC) ? pc_q : in_data_i.address;
    end else if (cmd_i.load_issue) begin
      mem_re = 1'b1;
      mem_ra = maddr;
    end else if (cmd_i.commit && ok && sto) begin
      mem_we = 1'b1;
      mem_wa = maddr;
      mem_wd = rb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_cnt_q <= '0;
    else if (cmd_i.clr && clr_cnt_q != ClearLast) clr_cnt_q <= clr_cnt_q + 16'd1;
  end

  // register file, two read ports selected from the fetched word
  assign dinsn = rd_data_q;
  always_comb begin
    ia = (dinsn[15:12] == OP_CMP || dinsn[15:12] == OP_HICON) ? dinsn[11:9] : dinsn[8:6];
    if (dinsn[15:12] == OP_STR)      ib = dinsn[11:9];
    else if (dinsn[15:12] == OP_RTI) ib = RegIdxW'(RegCount - 1);
    else                             ib = dinsn[2:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.regrd) begin
      insn_q <= dinsn;
      ra_q   <= vld_q[ia] ? regs[ia] : 16'd0;
      rb_q   <= vld_q[ib] ? regs[ib] : 16'd0;
    end
    if (cmd_i.commit && ok && wr) regs[rd] <= val;
    if (cmd_i.accept) addr_q <= in_data_i.address;
  end

  always_comb begin
    vld_d = vld_q;
    if (cmd_i.commit && ok && wr) vld_d[rd] = 1'b1;
  end

  // PC and PSR
  always_comb begin
    pc_d = pc_q; nzp_d = nzp_q; priv_d = priv_q;
    if (cmd_i.commit && ok) begin
      pc_d = npc;
      if (setnzp) nzp_d = nz;
      if (priv_clr) priv_d = 1'b0;
      if (priv_set) priv_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      pc_q   <= PcReset;
      nzp_q  <= NzpReset;
      priv_q <= 1'b1;
    end else begin
      vld_q  <= vld_d;
      pc_q   <= pc_d;
      nzp_q  <= nzp_d;
      priv_q <= priv_d;
    end
  end

  // restoring divider, one quotient bit per step
  assign dt   = {dr_q, dq_q[15]};
  assign dsub = dt - {1'b0, rb_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dcnt_q <= '0;
    else if (cmd_i.div_start) dcnt_q <= '0;
    else if (cmd_i.div_step) dcnt_q <= dcnt_q + 5'd1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dq_q <= ra_q;
      dr_q <= 16'd0;
    end else if (cmd_i.div_step) begin
      dq_q <= {dq_q[14:0], !dsub[16]};
      dr_q <= dsub[16] ? dt[15:0] : dsub[15:0];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && in_data_i.opcode != ITEM_EXEC) begin
      out_q           <= '0;
      out_q.next_pc   <= pc_q;
      out_q.nzp       <= nzp_q;
      out_q.privilege <= priv_q;
    end else if (cmd_i.readback) begin
      out_q           <= '0;
      out_q.next_pc   <= pc_q;
      out_q.nzp       <= nzp_q;
      out_q.privilege <= priv_q;
      out_q.mem_addr  <= addr_q;
      out_q.mem_data  <= rd_data_q;
    end else if (cmd_i.commit) begin
      out_q.status    <= st;
      out_q.next_pc   <= pc_d;
      out_q.nzp       <= nzp_d;
      out_q.privilege <= priv_d;
      out_q.reg_write <= ok && wr;
      out_q.reg_index <= (ok && wr) ? rd : '0;
      out_q.reg_value <= (ok && wr) ? val : 16'd0;
      out_q.mem_write <= ok && sto;
      out_q.mem_addr  <= (ok && sto) ? maddr : 16'd0;
      out_q.mem_data  <= (ok && sto) ? rb_q : 16'd0;
    end
  end

  assign out_data_o = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !ok) |=> ($stable(pc_q) && $stable(nzp_q) && $stable(priv_q)))
    else $error("architectural state changed on exception");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> !dcnt_q[4])
    else $error("divider stepped past last bit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !mem_re || (cmd_i.accept && in_data_i.opcode == ITEM_WR))
    else $error("unexpected read with write");

endmodule

// ===== sv/risc16_core_step.sv =====
// Top level of the risc16 core step block.
//
// Input channel in_*: one beat per item (write word, execute one instruction,
// read word). Output channel out_*: exactly one result beat per item.
// After reset the 64K-word memory is swept to zero, one word per cycle,
// with in_stall_o high. Registers reset to zero, PC to 0x8200,
// PSR to OS mode with Z set.
// Phases per item, from accept to result visible:
//   write word: accept; read word: accept, registered memory read;
//   instruction: fetch, operand read, execute; load: adds a second memory
//   access on the single memory port; DIV/MOD: adds 16 steps of the
//   one-bit-per-cycle divider after setup, then retire.
// One item is in flight at a time. A result sits in the output register
// while out_stall_i is high; in_stall_o stays high until the block is idle
// and the output register is empty or being taken in the same cycle.
module risc16_core_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rcs_pkg::rcs_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rcs_pkg::rcs_out_t  out_data_o
);
  import rcs_pkg::*;

  rcs_cmd_t cmd;
  rcs_sts_t sts;

  rcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_opcode_i (in_data_i.opcode),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rcs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// ===== tb/risc16_core_step_tb.sv =====
// Testbench for risc16_core_step: directed programs and random programs, checked per beat.
module risc16_core_step_tb;
  import rcs_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  rcs_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rcs_out_t out_data;

  risc16_core_step dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  always #1 clk = ~clk;

  // shadow core state
  logic [15:0] mem_q [0:65535];
  logic [15:0] regs_q [0:7];
  logic [15:0] pc_q;
  logic [2:0]  nzp_q;
  logic        os_q;

  rcs_out_t result_q [$];
  int       errors = 0;
  int       cycles = 0;
  bit       rx_idle_on = 1'b1;

  function automatic logic [15:0] sx(logic [15:0] v, int bits);
    logic [15:0] m;
    m = 16'h1 << (bits - 1);
    v = v & ((16'h1 << bits) - 16'h1);
    return (v ^ m) - m;
  endfunction

  function automatic logic [2:0] sign_bits(logic [15:0] v);
    if (v == 16'h0) return 3'b010;
    return v[15] ? 3'b100 : 3'b001;
  endfunction

  function automatic logic [2:0] cmp_bits(logic signed [16:0] a, logic signed [16:0] b);
    if (a < b) return 3'b100;
    return (a == b) ? 3'b010 : 3'b001;
  endfunction

  function automatic bit is_data(logic [15:0] a);
    return (a >= 16'h4000 && a <= 16'h7FFF) || a >= 16'hA000;
  endfunction

  function automatic bit data_ok(logic [15:0] a, bit os);
    if (a >= 16'h4000 && a <= 16'h7FFF) return 1'b1;
    return os && a >= 16'hA000;
  endfunction

  // advance the shadow core by one item, return the expected result beat
  function automatic rcs_out_t core_step(rcs_in_t it);
    rcs_out_t r;
    logic [15:0] insn, rs, rt, val, npc, maddr, ra;
    logic [2:0] rd, nz, st;
    logic [3:0] sh;
    bit wr, setnz, ld, sto;
    int priv;
    r = '0; val = 16'h0; maddr = 16'h0; rd = 3'd0; nz = 3'd0; st = ST_OK;
    wr = 1'b0; setnz = 1'b0; ld = 1'b0; sto = 1'b0; priv = -1;
    if (it.opcode != ITEM_EXEC) begin
      if (it.opcode == ITEM_WR) mem_q[it.address] = it.data;
      else if (it.opcode == ITEM_RD) begin
        r.mem_addr = it.address;
        r.mem_data = mem_q[it.address];
      end
      r.next_pc = pc_q; r.nzp = nzp_q; r.privilege = os_q;
      return r;
    end
    insn = mem_q[pc_q];
    rs = regs_q[insn[8:6]];
    rt = regs_q[insn[2:0]];
    npc = pc_q + 16'd1;
    if (is_data(pc_q)) st = ST_CODE;
    else if (!os_q && pc_q >= 16'h8000) st = ST_PRIV;
    if (st == ST_OK) begin
      case (insn[15:12])
        OP_BR: if ((nzp_q & insn[11:9]) != 3'b000) npc = pc_q + 16'd1 + sx(insn, 9);
        OP_ARITH: begin
          rd = insn[11:9]; wr = 1'b1;
          if (insn[5]) val = rs + sx(insn, 5);
          else case (insn[4:3])
            2'd0: val = rs + rt;
            2'd1: val = rs * rt;
            2'd2: val = rs - rt;
            default: val = (rt != 16'h0) ? rs / rt : 16'h0;
          endcase
          setnz = 1'b1; nz = sign_bits(val);
        end
        OP_CMP: begin
          ra = regs_q[insn[11:9]];
          case (insn[8:7])
            2'd0: nz = cmp_bits({ra[15], ra}, {rt[15], rt});
            2'd1: nz = cmp_bits({1'b0, ra}, {1'b0, rt});
            2'd2: nz = cmp_bits({ra[15], ra}, {insn[6], sx(insn, 7)});
            default: nz = cmp_bits({1'b0, ra}, {10'b0, insn[6:0]});
          endcase
          setnz = 1'b1;
        end
        OP_JSR: begin
          rd = 3'd7; wr = 1'b1; val = npc; setnz = 1'b1; nz = sign_bits(val);
          if (insn[11]) npc = {pc_q[15], insn[10:0], 4'b0};
          else npc = rs;
        end
        OP_LOGIC: begin
          rd = insn[11:9]; wr = 1'b1;
          if (insn[5]) val = rs & sx(insn, 5);
          else case (insn[4:3])
            2'd0: val = rs & rt;
            2'd1: val = ~rs;
            2'd2: val = rs | rt;
            default: val = rs ^ rt;
          endcase
          setnz = 1'b1; nz = sign_bits(val);
        end
        OP_LDR: begin rd = insn[11:9]; wr = 1'b1; ld = 1'b1; maddr = rs + sx(insn, 6); end
        OP_STR: begin sto = 1'b1; maddr = rs + sx(insn, 6); end
        OP_RTI: begin npc = regs_q[7]; priv = 0; end
        OP_CONST: begin
          rd = insn[11:9]; wr = 1'b1; val = sx(insn, 9); setnz = 1'b1;
          nz = sign_bits(val);
        end
        OP_SHIFT: begin
          rd = insn[11:9]; wr = 1'b1; sh = insn[3:0];
          case (insn[5:4])
            2'd0: val = rs << sh;
            2'd1: val = 16'($signed(rs) >>> sh);
            2'd2: val = rs >> sh;
            default: val = (rt != 16'h0) ? rs % rt : 16'h0;
          endcase
          setnz = 1'b1; nz = sign_bits(val);
        end
        OP_JMP: npc = insn[11] ? pc_q + 16'd1 + sx(insn, 11) : rs;
        OP_HICON: begin
          rd = insn[11:9]; wr = 1'b1; val = {insn[7:0], regs_q[rd][7:0]};
          setnz = 1'b1; nz = sign_bits(val);
        end
        OP_TRAP: begin
          rd = 3'd7; wr = 1'b1; val = npc; setnz = 1'b1; nz = sign_bits(val);
          npc = {8'h80, insn[7:0]}; priv = 1;
        end
        default: st = ST_INVALID;
      endcase
    end
    if (st == ST_OK && (ld || sto) && !data_ok(maddr, os_q)) st = ST_DATA;
    if (st == ST_OK) begin
      if (ld) begin val = mem_q[maddr]; setnz = 1'b1; nz = sign_bits(val); end
      if (sto) begin
        mem_q[maddr] = regs_q[insn[11:9]];
        r.mem_write = 1'b1; r.mem_addr = maddr; r.mem_data = mem_q[maddr];
      end
      if (setnz) nzp_q = nz;
      if (priv == 0) os_q = 1'b0;
      if (priv == 1) os_q = 1'b1;
      if (wr) begin
        regs_q[rd] = val;
        r.reg_write = 1'b1; r.reg_index = rd; r.reg_value = val;
      end
      pc_q = npc;
    end
    r.status = st; r.next_pc = pc_q; r.nzp = nzp_q; r.privilege = os_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // one item beat, with a random gap in front
  task automatic send_item(logic [1:0] op, logic [15:0] addr, logic [15:0] dat);
    rcs_in_t it;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.opcode = op; it.address = addr; it.data = dat;
    in_valid <= 1'b1;
    in_data <= it;
    result_q.push_back(core_step(it));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wr(logic [15:0] a, logic [15:0] d); send_item(ITEM_WR, a, d); endtask
  task automatic ex(); send_item(ITEM_EXEC, 16'($urandom), 16'($urandom)); endtask
  task automatic rd_back(logic [15:0] a); send_item(ITEM_RD, a, 16'($urandom)); endtask

  // result checker
  always @(posedge clk) begin
    rcs_out_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected beat", out_data.next_pc, 16'h0);
      end else begin
        w = result_q.pop_front();
        if (out_data.status != w.status)
          report_mismatch("status", 16'(out_data.status), 16'(w.status));
        if (out_data.next_pc != w.next_pc) report_mismatch("next_pc", out_data.next_pc, w.next_pc);
        if (out_data.nzp != w.nzp) report_mismatch("nzp", 16'(out_data.nzp), 16'(w.nzp));
        if (out_data.privilege != w.privilege)
          report_mismatch("privilege", 16'(out_data.privilege), 16'(w.privilege));
        if (out_data.reg_write != w.reg_write)
          report_mismatch("reg_write", 16'(out_data.reg_write), 16'(w.reg_write));
        if (out_data.reg_index != w.reg_index)
          report_mismatch("reg_index", 16'(out_data.reg_index), 16'(w.reg_index));
        if (out_data.reg_value != w.reg_value)
          report_mismatch("reg_value", out_data.reg_value, w.reg_value);
        if (out_data.mem_write != w.mem_write)
          report_mismatch("mem_write", 16'(out_data.mem_write), 16'(w.mem_write));
        if (out_data.mem_addr != w.mem_addr)
          report_mismatch("mem_addr", out_data.mem_addr, w.mem_addr);
        if (out_data.mem_data != w.mem_data)
          report_mismatch("mem_data", out_data.mem_data, w.mem_data);
      end
    end
  end

  // receiver stall: per beat a random hold
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rx_idle_on) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      stall_left <= $urandom_range(0, 14);
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("risc16_core_step_tb failed");
      $finish;
    end
  end

  function automatic logic [15:0] rnd_insn();
    logic [15:0] i;
    i = 16'($urandom);
    // keep unused opcodes rare
    if (i[15:12] inside {4'h3, 4'hB, 4'hE} && $urandom_range(0, 3) != 0) i[15:12] = OP_ARITH;
    return i;
  endfunction

  task automatic test_host_access();
    wr(16'h0000, 16'hFFFF);
    wr(16'hFFFF, 16'h0000);
    rd_back(16'h0000);
    rd_back(16'hFFFF);
    send_item(ITEM_NONE, 16'hFFFF, 16'hFFFF);
    rd_back(16'h1234);
  endtask

  task automatic test_os_program();
    logic [15:0] p;
    p = 16'h8200;
    wr(p, 16'h9000 | (3'd1 << 9) | 9'h0FF);                       // CONST R1 0xFF
    wr(p + 16'd1, 16'hD000 | (3'd1 << 9) | 8'hA0);                 // HICONST R1 0xA0 -> 0xA0FF
    wr(p + 16'd2, 16'h9000 | (3'd2 << 9) | 9'h1FF);                // CONST R2 -1
    wr(p + 16'd3, 16'h7000 | (3'd2 << 9) | (3'd1 << 6));           // STR R2,[R1]
    wr(p + 16'd4, 16'h6000 | (3'd3 << 9) | (3'd1 << 6));           // LDR R3,[R1]
    wr(p + 16'd5, 16'h1000 | (3'd4 << 9) | (3'd3 << 6) | 5'b11000); // DIV by R0 = 0
    wr(p + 16'd6, 16'hA000 | (3'd5 << 9) | (3'd2 << 6) | 6'b110000); // MOD by zero
    wr(p + 16'd7, 16'h2000 | (3'd2 << 9) | (2'd1 << 7) | 3'd1);    // CMPU
    wr(p + 16'd8, 16'h3000);                                       // invalid
    wr(p + 16'd9, 16'h6000 | (3'd3 << 9));                         // LDR from 0: denied
    wr(p + 16'd10, 16'hF000 | 8'h10);                              // TRAP
    repeat (8) ex();
    ex(); ex(); ex();
  endtask

  task automatic test_user_drop();
    // RTI to user code at 0x0010, then fault in user mode touching OS space
    wr(16'h8010, 16'h9000 | (3'd7 << 9) | 9'h010); // CONST R7 0x10
    wr(16'h8011, 16'h8000);                         // RTI
    wr(16'h0010, 16'hC800 | 11'h7EF);               // JMP -17 -> 0x0000
    wr(16'h0000, 16'hC000 | (3'd1 << 6));           // JMPR R1 -> OS data
    ex(); ex(); ex(); ex(); ex();
  endtask

  // random programs: fill a small code window then run it
  task automatic test_random_programs(int n_items);
    int k, j;
    logic [15:0] base;
    k = 0;
    while (k < n_items) begin
      if ($urandom_range(0, 15) == 0) begin
        wr(16'($urandom), 16'($urandom)); k++;
      end else if ($urandom_range(0, 15) == 0) begin
        rd_back(16'h4000 | 16'($urandom_range(0, 63))); k++;
      end else begin
        base = pc_q;
        for (j = 0; j < 8; j++) wr(base + 16'(j), rnd_insn());
        // sprinkle data words near the pointers registers may hold
        wr(16'h4000 | 16'($urandom_range(0, 63)), 16'($urandom));
        for (j = 0; j < 8; j++) ex();
        k += 17;
        // pull back into a code region if wandered off
        if (is_data(pc_q) || (!os_q && pc_q >= 16'h8000)) begin
          wr(pc_q, 16'h0000); ex(); k += 2;
        end
      end
      if (k % 400 < 17) rx_idle_on = ($urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < 65536; i++) mem_q[i] = 16'h0;
    for (i = 0; i < 8; i++) regs_q[i] = 16'h0;
    pc_q = PcReset; nzp_q = NzpReset; os_q = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_host_access();
    test_os_program();
    test_user_drop();
    test_random_programs(1850);
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("risc16_core_step_tb passed");
    end else begin
      $display("risc16_core_step_tb failed");
    end
    $finish;
  end
endmodule
